// ----- rtl/rpr_pkg.sv -----
// Shared types and constants for the RTC parameter RAM register file.
package rpr_pkg;

   localparam int BYTE_W = 8;
   localparam int TICK_W = 7;
   localparam int SEC_W = 32;
   localparam int BASE_W = 5;

   // Configuration register indexes.
   localparam logic CSR_TICK_STEP = 1'b0;
   localparam logic CSR_TICK_MATCH = 1'b1;

   localparam logic [TICK_W-1:0] TICK_STEP_RESET = 7'd2;
   localparam logic [TICK_W-1:0] TICK_MATCH_RESET = 7'd125;

   // Command decode.
   localparam logic [BYTE_W-1:0] EXT_MASK = 8'h78;
   localparam logic [BYTE_W-1:0] EXT_CODE = 8'h38;
   localparam logic [BASE_W-1:0] WP_ADDR = 5'h0D;
   localparam logic [BYTE_W-1:0] UNMAPPED_DATA = 8'hFF;

   typedef struct packed {
      logic                command;
      logic [BYTE_W-1:0]   cmd_byte;
      logic [BYTE_W-1:0]   ext_byte;
      logic [BYTE_W-1:0]   data_byte;
   } req_item_type;

endpackage

// ----- rtl/rpr_req_if.sv -----
// Request channel: one transaction or tick per item.
interface rpr_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] cmd_byte;
   logic [7:0] ext_byte;
   logic [7:0] data_byte;

   modport source (output valid, command, cmd_byte, ext_byte, data_byte, input ready);
   modport sink (input valid, command, cmd_byte, ext_byte, data_byte, output ready);
endinterface

// ----- rtl/rpr_rsp_if.sv -----
// Response channel: one result item per request item.
interface rpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       one_sec_line;
   logic       save_request;

   modport source (output valid, read_data, one_sec_line, save_request, input ready);
   modport sink (input valid, read_data, one_sec_line, save_request, output ready);
endinterface

// ----- rtl/rpr_pram.sv -----
// Parameter RAM with per-entry valid bits; unwritten entries read as zero.
module rpr_pram import rpr_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rtc_pram_register_file.sv -----
// Order: an accepted item is registered in the decode stage, and the result register
// loads when the item leaves that stage; a result that is not taken holds the stage.
// Throughput: one item per cycle while results are taken; the PRAM read is issued at acceptance and
// registered, and all state updates happen when the item leaves the decode stage.
// Reset is synchronous: control state, clock state and the PRAM valid bits clear
// together, so the PRAM reads as zero at once with no clearing pass.
module rtc_pram_register_file import rpr_pkg::*; #(
   parameter int PRAM_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [TICK_W-1:0] csr_wdata,
   rpr_req_if.sink           req_chan,
   rpr_rsp_if.source         rsp_chan
);

   localparam int ADDR_W = $clog2(PRAM_DEPTH);

   logic [TICK_W-1:0] tick_step_ff;
   logic [TICK_W-1:0] tick_match_ff;

   logic [SEC_W-1:0]  seconds_ff, seconds_in;
   logic              wp_ff, wp_in;
   logic [BYTE_W-1:0] prescaler_ff, prescaler_in;
   logic              level_ff, level_in;

   logic              s1_valid_ff;
   req_item_type      s1_item_ff;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_save_ff, rsp_save_in;
   logic              rsp_level_ff;

   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [BYTE_W-1:0] fwd_data_ff;

   logic              accept;
   logic              s1_go;
   logic [ADDR_W-1:0] req_addr;
   logic [BYTE_W-1:0] mem_q;
   logic [BYTE_W-1:0] pram_q;

   logic              is_write, extended, is_ram;
   logic [BASE_W-1:0] base;
   logic [ADDR_W-1:0] s1_addr;
   logic              pram_we;
   logic [BYTE_W-1:0] presc_sum;

   // Handshake: the decode stage moves on whenever the result register is free or being taken.
   assign s1_go = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign accept = req_chan.valid && req_chan.ready;

   // PRAM address of the incoming item, used to start the read early.
   always_comb begin
      if ((req_chan.cmd_byte & EXT_MASK) == EXT_CODE) begin
         req_addr = ADDR_W'({req_chan.cmd_byte[2:0], req_chan.ext_byte[6:2]});
      end else begin
         req_addr = ADDR_W'(req_chan.cmd_byte[6:2]);
      end
   end

   rpr_pram #(.DEPTH(PRAM_DEPTH)) u_pram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pram_we),
      .wr_addr (s1_addr),
      .wr_data (s1_item_ff.data_byte),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_q)
   );

   // Decode of the item in the stage.
   assign is_write = !s1_item_ff.cmd_byte[7];
   assign extended = (s1_item_ff.cmd_byte & EXT_MASK) == EXT_CODE;
   assign base = s1_item_ff.cmd_byte[6:2];
   assign is_ram = base inside {[5'h08:5'h0B], [5'h10:5'h1F]};

   always_comb begin
      if (extended) begin
         s1_addr = ADDR_W'({s1_item_ff.cmd_byte[2:0], s1_item_ff.ext_byte[6:2]});
      end else begin
         s1_addr = ADDR_W'(base);
      end
   end

   // The write of the previous item lands at the edge this item's read is taken.
   assign pram_q = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : mem_q;

   assign pram_we = s1_go && !s1_item_ff.command && is_write && !wp_ff
                    && (extended || is_ram);

   assign presc_sum = prescaler_ff + {1'b0, tick_step_ff};

   always_comb begin
      seconds_in = seconds_ff;
      wp_in = wp_ff;
      prescaler_in = prescaler_ff;
      level_in = level_ff;
      rsp_data_in = '0;
      rsp_save_in = 1'b0;
      if (s1_item_ff.command) begin
         prescaler_in = presc_sum;
         if (presc_sum >= {1'b0, tick_match_ff}) begin
            level_in = !level_ff;
            if (!level_ff) begin
               seconds_in = seconds_ff + SEC_W'(1);
            end
            prescaler_in = presc_sum - {1'b0, tick_match_ff};
         end
      end else if (extended) begin
         if (!is_write) begin
            rsp_data_in = pram_q;
         end
      end else if (!is_write) begin
         if (base[4:3] == 2'b00) begin
            rsp_data_in = seconds_ff[{base[1:0], 3'b000} +: BYTE_W];
         end else if (is_ram) begin
            rsp_data_in = pram_q;
         end else begin
            rsp_data_in = UNMAPPED_DATA;
         end
      end else if (base == WP_ADDR) begin
         wp_in = s1_item_ff.data_byte[7];
         rsp_save_in = !wp_ff && s1_item_ff.data_byte[7];
      end else if (!wp_ff && base[4:3] == 2'b00) begin
         seconds_in[{base[1:0], 3'b000} +: BYTE_W] = s1_item_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= TICK_STEP_RESET;
         tick_match_ff <= TICK_MATCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICK_STEP: begin
               tick_step_ff <= csr_wdata;
            end
            CSR_TICK_MATCH: begin
               tick_match_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff <= '0;
         wp_ff <= 1'b1;
         prescaler_ff <= '0;
         level_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            seconds_ff <= seconds_in;
            wp_ff <= wp_in;
            prescaler_ff <= prescaler_in;
            level_ff <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pram_we) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{command:   req_chan.command,
                         cmd_byte:  req_chan.cmd_byte,
                         ext_byte:  req_chan.ext_byte,
                         data_byte: req_chan.data_byte};
      end
      if (pram_we) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= s1_item_ff.data_byte;
      end
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
         rsp_save_ff <= rsp_save_in;
         rsp_level_ff <= level_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.one_sec_line = rsp_level_ff;
   assign rsp_chan.save_request = rsp_save_ff;

`ifndef SYNTHESIS
   // Reset leaves the block protected with the line low.
   a_reset_state: assert property (@(posedge clock) reset |=> wp_ff && !level_ff)
      else $error("write protect or line level wrong after reset");

   // A pending save request means protection is on and no data was read.
   a_save_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_save_ff |-> wp_ff && rsp_data_ff == '0)
      else $error("save request without protection or with read data");

   // A stalled result with a busy stage must hold off new items.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("item accepted while the stage cannot drain");

   // The line level reported matches the live state while the result waits.
   a_level_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !s1_go |-> rsp_level_ff == level_ff)
      else $error("reported line level differs from state");
`endif

endmodule
